/* rtl/usmg_pkg.sv */
// Shared types and constants for the UV-sphere mesh generator.
// No dependencies; used by every other file of the block.
package usmg_pkg;

    // Result kinds.
    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_MORE   = 2'd1;
    localparam logic [1:0] KIND_LAST   = 2'd2;
    localparam logic [1:0] KIND_REJECT = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RADIUS  = 2'd0;
    localparam logic [1:0] CFG_SECTORS = 2'd1;
    localparam logic [1:0] CFG_STACKS  = 2'd2;

    localparam logic [15:0] RADIUS_RST  = 16'd256;
    localparam logic [7:0]  SECTORS_RST = 8'd36;
    localparam logic [7:0]  STACKS_RST  = 8'd18;

    // Divider: 25-bit dividend, 8-bit divisor, 17 quotient bits, one per stage.
    localparam int DIVIDEND_W = 25;
    localparam int QUO_W      = 17;
    localparam int DIV_LAT    = QUO_W;

    // Sine pipeline depth and the Q30 Taylor coefficients of sin(pi/2*x).
    localparam int SINE_LAT = 9;
    localparam logic [31:0] SINE_K1  = 32'd1686629713;
    localparam logic [31:0] SINE_K11 = 32'd3864;
    localparam logic [31:0] SINE_K [0:3] = '{32'd172272, 32'd5026995, 32'd85569306,
                                             32'd693598668};
    localparam logic [32:0] Q30_ONE = 33'd1073741824;

    // Total depth from input register to the last arithmetic stage.
    localparam int PIPE_LAT = DIV_LAT + SINE_LAT + 4;

    typedef struct packed {
        logic        mode;
        logic        bad;
        logic        first;
        logic        second;
        logic [15:0] k1;
        logic [15:0] k2;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
    } t_carry;

endpackage

/* rtl/usmg_div.sv */
// Pipelined restoring divider, one quotient bit per stage, round-to-nearest
// handled by the caller through the dividend. Depends on usmg_pkg.
module usmg_div (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [usmg_pkg::DIVIDEND_W-1:0] i_dividend,
    input  logic [7:0]                      i_divisor,
    output logic [usmg_pkg::QUO_W-1:0]      o_quotient
);
    localparam int QW = usmg_pkg::QUO_W;
    localparam int DW = usmg_pkg::DIVIDEND_W;
    localparam int NS = usmg_pkg::DIV_LAT;

    logic [7:0]    r_rem [0:NS-1];
    logic [QW-1:0] r_low [0:NS-1];
    logic [QW-1:0] r_quo [0:NS-1];
    logic [7:0]    r_d   [0:NS-1];

    logic [7:0]    n_rem [0:NS-1];
    logic [QW-1:0] n_low [0:NS-1];
    logic [QW-1:0] n_quo [0:NS-1];
    logic [7:0]    n_d   [0:NS-1];

    always_comb begin
        logic [7:0]    p_rem;
        logic [QW-1:0] p_low;
        logic [QW-1:0] p_quo;
        logic [7:0]    p_d;
        logic [8:0]    t;
        logic          ge;
        for (int j = 0; j < NS; j++) begin
            if (j == 0) begin
                p_rem = i_dividend[DW-1:QW];
                p_low = i_dividend[QW-1:0];
                p_quo = '0;
                p_d   = i_divisor;
            end else begin
                p_rem = r_rem[j-1];
                p_low = r_low[j-1];
                p_quo = r_quo[j-1];
                p_d   = r_d[j-1];
            end
            t        = {p_rem, p_low[QW-1]};
            ge       = (t >= {1'b0, p_d});
            n_rem[j] = ge ? 8'(t - {1'b0, p_d}) : t[7:0];
            n_low[j] = {p_low[QW-2:0], 1'b0};
            n_quo[j] = {p_quo[QW-2:0], ge};
            n_d[j]   = p_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NS; j++) begin
                r_rem[j] <= n_rem[j];
                r_low[j] <= n_low[j];
                r_quo[j] <= n_quo[j];
                r_d[j]   <= n_d[j];
            end
        end
    end

    assign o_quotient = r_quo[NS-1];

endmodule

/* rtl/usmg_sine.sv */
// Pipelined Q30 sine of a 16-bit phase: quarter-wave fold, then a Horner
// polynomial with one multiply per stage. Depends on usmg_pkg.
module usmg_sine (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_phase,
    output logic [30:0] o_mag,
    output logic        o_neg
);
    logic [16:0] r_x   [0:7];
    logic [30:0] r_x2  [2:6];
    logic [62:0] r_p   [2:6];
    logic        r_neg [0:8];
    logic [32:0] r_xx;
    logic [48:0] r_pf;
    logic [30:0] r_m;

    logic [13:0] f;
    logic [14:0] q;
    logic [32:0] m_full;

    assign f = i_phase[13:0];
    assign q = i_phase[14] ? 15'(15'd16384 - {1'b0, f}) : {1'b0, f};
    assign m_full = 33'((r_pf + (49'd1 << 15)) >> 16);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]   <= {q, 2'b00};
            r_neg[0] <= i_phase[15];
            for (int k = 1; k < 9; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
            for (int k = 1; k < 8; k++) begin
                r_x[k] <= r_x[k-1];
            end
            r_xx   <= 33'({17'd0, r_x[0]} * {17'd0, r_x[0]});
            r_x2[2] <= r_xx[32:2];
            r_p[2]  <= 63'({32'd0, r_xx[32:2]} * {31'd0, usmg_pkg::SINE_K11});
            // Each Horner step rounds the previous product back to Q30.
            for (int k = 3; k < 7; k++) begin
                r_x2[k] <= r_x2[k-1];
                r_p[k]  <= 63'({32'd0, r_x2[k-1]} * {31'd0, 32'(usmg_pkg::SINE_K[k-3]
                           - 32'((r_p[k-1] + (63'd1 << 29)) >> 30))});
            end
            r_pf <= 49'({32'd0, r_x[6]} * {17'd0, 32'(usmg_pkg::SINE_K1
                    - 32'((r_p[6] + (63'd1 << 29)) >> 30))});
            r_m  <= (m_full > usmg_pkg::Q30_ONE) ? usmg_pkg::Q30_ONE[30:0] : m_full[30:0];
        end
    end

    assign o_mag = r_m;
    assign o_neg = r_neg[8];

endmodule

/* rtl/uv_sphere_mesh_generator.sv */
// UV-sphere mesh generator: vertices (position, normal, texture) and quad
// triangles. Depends on usmg_pkg, usmg_div and usmg_sine.
//
//   channel   direction  handshake          payload
//   request   in         i_valid / o_stall  i_mode, i_stack_index, i_sector_index
//   result    out        o_valid / i_stall  o_kind, o_pos_*, o_norm_*, o_tex_*, o_corner_*
//   config    in         i_cfg_we           i_cfg_index, i_cfg_data
//
// One request enters per cycle while o_stall is low.
// The pipeline is made up of the 17-stage divider, the 9-stage sine and 4 product stages.
// A quad with two triangles gives its second triangle as a further result, taking one
// request slot. Reset is synchronous and clears the pipeline valid bits.
// An output stall freezes the whole pipeline while a result is held; nothing is dropped.
module uv_sphere_mesh_generator #(
    parameter int MAX_SECTORS = 255,
    parameter int MAX_STACKS  = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_mode,
    input  logic [7:0]         i_stack_index,
    input  logic [7:0]         i_sector_index,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [16:0] o_pos_x,
    output logic signed [16:0] o_pos_y,
    output logic signed [16:0] o_pos_z,
    output logic signed [15:0] o_norm_x,
    output logic signed [15:0] o_norm_y,
    output logic signed [15:0] o_norm_z,
    output logic [16:0]        o_tex_u,
    output logic [16:0]        o_tex_v,
    output logic [15:0]        o_corner_a,
    output logic [15:0]        o_corner_b,
    output logic [15:0]        o_corner_c
);
    localparam int LAT = usmg_pkg::PIPE_LAT;
    localparam int DL  = usmg_pkg::DIV_LAT;

    logic [15:0] r_radius;
    logic [7:0]  r_sectors;
    logic [7:0]  r_stacks;

    logic               r_vld [0:LAT-1];
    usmg_pkg::t_carry   r_cy  [0:LAT-1];
    usmg_pkg::t_carry   n_cy;
    usmg_pkg::t_carry   n_mid;

    logic        adv;
    logic        r_out_valid;
    logic        r_has2;
    logic [15:0] r_sec_a, r_sec_b, r_sec_c;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius  <= usmg_pkg::RADIUS_RST;
            r_sectors <= usmg_pkg::SECTORS_RST;
            r_stacks  <= usmg_pkg::STACKS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                usmg_pkg::CFG_RADIUS:  r_radius  <= i_cfg_data;
                usmg_pkg::CFG_SECTORS: r_sectors <= i_cfg_data[7:0];
                usmg_pkg::CFG_STACKS:  r_stacks  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves unless a finished result is held at the output.
    assign adv     = !r_out_valid || (!i_stall && !r_has2);
    assign o_stall = !adv;

    // Entry: range checks and triangle indexes.
    always_comb begin
        logic        cfg_bad;
        logic [8:0]  n1;
        logic [15:0] k1;
        cfg_bad = (r_sectors == 8'd0) || (r_stacks == 8'd0)
                  || (int'(r_sectors) > MAX_SECTORS) || (int'(r_stacks) > MAX_STACKS);
        n1 = {1'b0, r_sectors} + 9'd1;
        k1 = 16'({9'd0, i_stack_index} * {8'd0, n1} + {9'd0, i_sector_index});
        n_cy.mode   = i_mode;
        n_cy.bad    = cfg_bad || (i_mode ? (i_stack_index >= r_stacks
                                            || i_sector_index >= r_sectors)
                                         : (i_stack_index > r_stacks
                                            || i_sector_index > r_sectors));
        n_cy.first  = (i_stack_index != 8'd0);
        n_cy.second = (i_stack_index != 8'(r_stacks - 8'd1));
        n_cy.k1     = k1;
        n_cy.k2     = 16'(k1 + {7'd0, n1});
        n_cy.tex_u  = '0;
        n_cy.tex_v  = '0;
    end

    // Rounded quotients: lon = se*65536/ns, lat = st*32768/nt, tex_v = st*65536/nt.
    logic [usmg_pkg::QUO_W-1:0] q_lon, q_lat, q_tex;

    usmg_div u_div_lon (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend ({1'b0, i_sector_index, 16'd0} + {18'd0, r_sectors[7:1]}),
        .i_divisor  (r_sectors),
        .o_quotient (q_lon)
    );

    usmg_div u_div_lat (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend ({2'b0, i_stack_index, 15'd0} + {18'd0, r_stacks[7:1]}),
        .i_divisor  (r_stacks),
        .o_quotient (q_lat)
    );

    usmg_div u_div_tex (
        .i_clk      (i_clk),
        .i_en       (adv),
        .i_dividend ({1'b0, i_stack_index, 16'd0} + {18'd0, r_stacks[7:1]}),
        .i_divisor  (r_stacks),
        .o_quotient (q_tex)
    );

    // The texture quotients join the carried fields where the dividers finish.
    always_comb begin
        n_mid       = r_cy[DL-1];
        n_mid.tex_u = q_lon;
        n_mid.tex_v = q_tex;
    end

    logic [15:0] ph_lat, ph_lon;
    assign ph_lat = 16'(16'h4000 - q_lat[15:0]);
    assign ph_lon = q_lon[15:0];

    logic [30:0] m_sl, m_cl, m_so, m_co;
    logic        g_sl, g_cl, g_so, g_co;

    usmg_sine u_sin_lat (
        .i_clk (i_clk), .i_en (adv), .i_phase (ph_lat),
        .o_mag (m_sl), .o_neg (g_sl)
    );
    usmg_sine u_cos_lat (
        .i_clk (i_clk), .i_en (adv), .i_phase (16'(ph_lat + 16'h4000)),
        .o_mag (m_cl), .o_neg (g_cl)
    );
    usmg_sine u_sin_lon (
        .i_clk (i_clk), .i_en (adv), .i_phase (ph_lon),
        .o_mag (m_so), .o_neg (g_so)
    );
    usmg_sine u_cos_lon (
        .i_clk (i_clk), .i_en (adv), .i_phase (16'(ph_lon + 16'h4000)),
        .o_mag (m_co), .o_neg (g_co)
    );

    // Product stages on magnitudes; signs ride alongside.
    logic [61:0] r1_pxx, r1_pxy;
    logic [30:0] r1_slm;
    logic        r1_gx, r1_gy, r1_gz;
    logic [30:0] r2_dxm, r2_dym, r2_slm;
    logic [14:0] r2_nxm, r2_nym, r2_nzm;
    logic        r2_gx, r2_gy, r2_gz;
    logic [46:0] r3_qx, r3_qy, r3_qz;
    logic [15:0] r3_nx, r3_ny, r3_nz;
    logic        r3_gx, r3_gy, r3_gz;
    logic [16:0] r4_px, r4_py, r4_pz;
    logic [15:0] r4_nx, r4_ny, r4_nz;
    logic [16:0] m4x, m4y, m4z;

    assign m4x = 17'((r3_qx + (47'd1 << 29)) >> 30);
    assign m4y = 17'((r3_qy + (47'd1 << 29)) >> 30);
    assign m4z = 17'((r3_qz + (47'd1 << 29)) >> 30);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cy[0] <= n_cy;
            for (int k = 1; k < LAT; k++) begin
                r_cy[k] <= (k == DL) ? n_mid : r_cy[k-1];
            end

            r1_pxx <= {31'd0, m_cl} * {31'd0, m_co};
            r1_pxy <= {31'd0, m_cl} * {31'd0, m_so};
            r1_slm <= m_sl;
            r1_gx  <= g_cl ^ g_co;
            r1_gy  <= g_cl ^ g_so;
            r1_gz  <= g_sl;

            r2_dxm <= 31'((r1_pxx + (62'd1 << 29)) >> 30);
            r2_dym <= 31'((r1_pxy + (62'd1 << 29)) >> 30);
            r2_nxm <= 15'((r1_pxx + (62'd1 << 45)) >> 46);
            r2_nym <= 15'((r1_pxy + (62'd1 << 45)) >> 46);
            r2_nzm <= 15'((r1_slm + (31'd1 << 15)) >> 16);
            r2_slm <= r1_slm;
            r2_gx  <= r1_gx;
            r2_gy  <= r1_gy;
            r2_gz  <= r1_gz;

            r3_qx <= {31'd0, r_radius} * {16'd0, r2_dxm};
            r3_qy <= {31'd0, r_radius} * {16'd0, r2_dym};
            r3_qz <= {31'd0, r_radius} * {16'd0, r2_slm};
            r3_nx <= r2_gx ? 16'(-{1'b0, r2_nxm}) : {1'b0, r2_nxm};
            r3_ny <= r2_gy ? 16'(-{1'b0, r2_nym}) : {1'b0, r2_nym};
            r3_nz <= r2_gz ? 16'(-{1'b0, r2_nzm}) : {1'b0, r2_nzm};
            r3_gx <= r2_gx;
            r3_gy <= r2_gy;
            r3_gz <= r2_gz;

            r4_px <= r3_gx ? 17'(-m4x) : m4x;
            r4_py <= r3_gy ? 17'(-m4y) : m4y;
            r4_pz <= r3_gz ? 17'(-m4z) : m4z;
            r4_nx <= r3_nx;
            r4_ny <= r3_ny;
            r4_nz <= r3_nz;
        end
    end

    // Pipeline tail: which results the item at the last stage produces.
    usmg_pkg::t_carry tl;
    logic             tl_vld, tl_vtx, tl_tri, tl_any;
    assign tl     = r_cy[LAT-1];
    assign tl_vld = r_vld[LAT-1];
    assign tl_vtx = !tl.bad && !tl.mode;
    assign tl_tri = !tl.bad && tl.mode;
    assign tl_any = tl.bad || !tl.mode || tl.first || tl.second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
            r_has2      <= 1'b0;
        end else begin
            if (adv) begin
                r_vld[0] <= i_valid;
                for (int k = 1; k < LAT; k++) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            priority if (r_has2 && !i_stall) begin
                r_out_valid <= 1'b1;
                r_has2      <= 1'b0;
            end else if (adv) begin
                r_out_valid <= tl_vld && tl_any;
                r_has2      <= tl_vld && tl_tri && tl.first && tl.second;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        priority if (r_has2 && !i_stall) begin
            o_kind     <= usmg_pkg::KIND_LAST;
            o_corner_a <= r_sec_a;
            o_corner_b <= r_sec_b;
            o_corner_c <= r_sec_c;
        end else if (adv) begin
            priority if (tl.bad) begin
                o_kind <= usmg_pkg::KIND_REJECT;
            end else if (!tl.mode) begin
                o_kind <= usmg_pkg::KIND_VERTEX;
            end else if (tl.first && tl.second) begin
                o_kind <= usmg_pkg::KIND_MORE;
            end else begin
                o_kind <= usmg_pkg::KIND_LAST;
            end
            o_pos_x  <= tl_vtx ? r4_px : '0;
            o_pos_y  <= tl_vtx ? r4_py : '0;
            o_pos_z  <= tl_vtx ? r4_pz : '0;
            o_norm_x <= tl_vtx ? r4_nx : '0;
            o_norm_y <= tl_vtx ? r4_ny : '0;
            o_norm_z <= tl_vtx ? r4_nz : '0;
            o_tex_u  <= tl_vtx ? tl.tex_u : '0;
            o_tex_v  <= tl_vtx ? tl.tex_v : '0;
            if (tl_tri && tl.first) begin
                o_corner_a <= tl.k1;
                o_corner_b <= tl.k2;
                o_corner_c <= 16'(tl.k1 + 16'd1);
            end else if (tl_tri) begin
                o_corner_a <= 16'(tl.k1 + 16'd1);
                o_corner_b <= tl.k2;
                o_corner_c <= 16'(tl.k2 + 16'd1);
            end else begin
                o_corner_a <= '0;
                o_corner_b <= '0;
                o_corner_c <= '0;
            end
            r_sec_a <= 16'(tl.k1 + 16'd1);
            r_sec_b <= tl.k2;
            r_sec_c <= 16'(tl.k2 + 16'd1);
        end
    end

    assign o_valid = r_out_valid;

endmodule

/* rtl/usmg_checker.sv */
// Port-level checks for the UV-sphere mesh generator, bound to its top level.
// Depends on usmg_pkg and uv_sphere_mesh_generator.
module usmg_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_stall,
    input logic               o_stall,
    input logic               o_valid,
    input logic [1:0]         o_kind,
    input logic signed [16:0] o_pos_x,
    input logic signed [15:0] o_norm_z,
    input logic [16:0]        o_tex_u,
    input logic [15:0]        o_corner_a
);
    // Reset empties the output.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // A stalled result transaction holds its kind.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_kind))
        else $error("stalled result changed");

    // The first of two triangles, once taken, is followed at once by the last one.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_kind == usmg_pkg::KIND_MORE
        |=> o_valid && o_kind == usmg_pkg::KIND_LAST)
        else $error("second triangle missing");

    // No new request is taken while the first triangle of a pair is at the output.
    a_pair_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == usmg_pkg::KIND_MORE |-> o_stall)
        else $error("request accepted during triangle pair");

    // A rejection carries no geometry and no indexes.
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == usmg_pkg::KIND_REJECT
        |-> o_pos_x == 0 && o_norm_z == 0 && o_tex_u == 0 && o_corner_a == 0)
        else $error("rejected result has nonzero fields");

endmodule

bind uv_sphere_mesh_generator usmg_checker u_usmg_checker (.*);
